/* design/assert_macros.svh */
// assertion macros shared by the rtl files
// no dependencies; each macro takes its own clock and active-low reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication
`define ASSERT_NXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

/* design/fnc_pkg.sv */
// shared constants and table functions for the frequency to note code block
// octave, semitone, fine and extra-fine step tables; no dependencies
package fnc_pkg;

    localparam int VAL_W = 32;
    localparam int DIV_W = 26;
    localparam int CODE_W = 16;

    typedef logic [VAL_W-1:0]  val_t;
    typedef logic [DIV_W-1:0]  step_t;
    typedef logic [CODE_W-1:0] code_t;
    typedef logic [3:0]        slot_t;
    typedef logic [1:0]        stage_t;

    localparam stage_t STAGE_OCT   = 2'd0;
    localparam stage_t STAGE_SEMI  = 2'd1;
    localparam stage_t STAGE_FINE  = 2'd2;
    localparam stage_t STAGE_XFINE = 2'd3;

    localparam code_t OCT_WEIGHT = 16'd3072;

    localparam step_t OCT_STEPS [16] = '{
        26'd2044, 26'd4088, 26'd8176, 26'd16352, 26'd32703, 26'd65406,
        26'd130813, 26'd261626, 26'd523251, 26'd1046502, 26'd2093005,
        26'd4186009, 26'd8372018, 26'd16744036, 26'd33488072, 26'd66976145
    };
    localparam step_t SEMI_STEPS [12] = '{
        26'd32768, 26'd34716, 26'd36781, 26'd38968, 26'd41285, 26'd43740,
        26'd46341, 26'd49097, 26'd52016, 26'd55109, 26'd58386, 26'd61858
    };
    localparam step_t FINE_STEPS [16] = '{
        26'd32768, 26'd32887, 26'd33005, 26'd33125, 26'd33245, 26'd33365,
        26'd33486, 26'd33607, 26'd33728, 26'd33850, 26'd33973, 26'd34095,
        26'd34219, 26'd34343, 26'd34467, 26'd34591
    };
    localparam step_t XFINE_STEPS [16] = '{
        26'd32768, 26'd32775, 26'd32783, 26'd32790, 26'd32798, 26'd32805,
        26'd32812, 26'd32820, 26'd32827, 26'd32835, 26'd32842, 26'd32849,
        26'd32857, 26'd32864, 26'd32872, 26'd32879
    };

    // last valid slot of each table
    function automatic slot_t last_slot(input stage_t stage);
        return (stage == STAGE_SEMI) ? 4'd11 : 4'd15;
    endfunction

    // table entry for a stage and slot
    function automatic step_t step_entry(input stage_t stage, input slot_t idx);
        step_t e;
        unique case (stage)
            STAGE_OCT:   e = OCT_STEPS[idx];
            STAGE_SEMI:  e = (idx < 4'd12) ? SEMI_STEPS[idx] : SEMI_STEPS[11];
            STAGE_FINE:  e = FINE_STEPS[idx];
            STAGE_XFINE: e = XFINE_STEPS[idx];
            default:     e = OCT_STEPS[idx];
        endcase
        return e;
    endfunction

    // first slot whose successor exceeds v, else the last slot
    function automatic slot_t find_slot(input stage_t stage, input val_t v);
        slot_t idx;
        slot_t lst;
        lst = last_slot(stage);
        idx = lst;
        for (int i = 15; i >= 1; i--) begin
            if (4'(i) <= lst && {{(VAL_W-DIV_W){1'b0}}, step_entry(stage, 4'(i))} > v)
            begin
                idx = 4'(i - 1);
            end
        end
        return idx;
    endfunction

endpackage

/* design/fnc_div.sv */
// bit-serial restoring divider: quot = floor(dividend * 32768 / divisor)
// one quotient bit per cycle; depends on fnc_pkg and assert_macros.svh
`include "assert_macros.svh"

module fnc_div (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  fnc_pkg::val_t  dividend,
    input  fnc_pkg::step_t divisor,
    output logic           done,
    output fnc_pkg::val_t  quot
);
    import fnc_pkg::*;

    // scaled dividend is dividend followed by 15 zero bits; the quotient
    // fits in 32 bits, so the top 15 dividend bits start as the remainder
    localparam int SCALE_SH = 15;

    logic            busy_reg,  busy_next;
    logic            done_reg,  done_next;
    logic [4:0]      cnt_reg,   cnt_next;
    step_t           rem_reg,   rem_next;
    step_t           den_reg,   den_next;
    val_t            dq_reg,    dq_next;

    logic [DIV_W:0]  trial;
    logic            ge;

    // one restoring step
    assign trial = {rem_reg, dq_reg[VAL_W-1]};
    assign ge    = trial >= {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        dq_next   = dq_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = {{(DIV_W-SCALE_SH){1'b0}},
                         dividend[VAL_W-1:VAL_W-SCALE_SH]};
            den_next  = divisor;
            dq_next   = {dividend[VAL_W-SCALE_SH-1:0], {SCALE_SH{1'b0}}};
        end
        else if (busy_reg)
        begin
            rem_next = ge ? DIV_W'(trial - {1'b0, den_reg}) : trial[DIV_W-1:0];
            dq_next  = {dq_reg[VAL_W-2:0], ge};
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        dq_reg  <= dq_next;
    end

    assign done = done_reg;
    assign quot = dq_reg;

    `ASSERT_IMP(a_start_idle, clk, rst_n, start, !busy_reg)
    `ASSERT_IMP(a_done_idle, clk, rst_n, done_reg, !busy_reg)

endmodule

/* design/frequency_to_note_code.sv */
// frequency to note code converter, top level
// uses fnc_pkg, fnc_div and assert_macros.svh
//
// input channel: freq_valid / freq_stall carry freq_millihz, a frequency in
// millihertz. output channel: note_valid / note_stall carry note_code, a
// 16-bit pitch code (octave, semitone, fine and extra-fine digits).
// a beat moves on a rising edge with valid high and stall low.
// one item is in work at a time: freq_stall is high from the accepting edge
// until the sequencer is back in idle. after the accepting edge come three
// table searches, each followed by a 32-step rescale in the shared
// bit-serial divider, then one last search and the finish state, which loads
// the result register and raises note_valid once the register is free.
// the result register parts the two sides: a new item is accepted while a
// result still waits; if note_stall holds the result, the next finished
// item waits in the sequencer until the register frees up.
// reset clears the sequencer, the divider and the output valid; no item
// or result survives it, and the block is ready as soon as reset is released.
`include "assert_macros.svh"

module frequency_to_note_code (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           freq_valid,
    output logic           freq_stall,
    input  logic [31:0]    freq_millihz,
    output logic           note_valid,
    input  logic           note_stall,
    output logic [15:0]    note_code
);
    import fnc_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SEARCH = 2'd1;
    localparam logic [1:0] ST_DIV    = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0]  state_reg, state_next;
    stage_t      stage_reg, stage_next;
    val_t        val_reg,   val_next;
    code_t       code_reg,  code_next;
    logic        nv_reg,    nv_next;
    code_t       nc_reg,    nc_next;

    logic        accept;
    slot_t       slot;
    code_t       digit;
    logic        div_start;
    logic        div_done;
    val_t        div_quot;

    assign accept = freq_valid && !freq_stall;
    assign slot   = find_slot(stage_reg, val_reg);

    // weighted digit for the current stage
    always_comb
    begin
        unique case (stage_reg)
            STAGE_OCT:   digit = CODE_W'(slot * OCT_WEIGHT) - OCT_WEIGHT;
            STAGE_SEMI:  digit = {4'b0, slot, 8'b0};
            STAGE_FINE:  digit = {8'b0, slot, 4'b0};
            STAGE_XFINE: digit = {12'b0, slot};
            default:     digit = '0;
        endcase
    end

    // shared rescale unit
    fnc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (val_reg),
        .divisor  (step_entry(stage_reg, slot)),
        .done     (div_done),
        .quot     (div_quot)
    );

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        stage_next = stage_reg;
        val_next   = val_reg;
        code_next  = code_reg;
        nv_next    = nv_reg;
        nc_next    = nc_reg;
        div_start  = 1'b0;
        if (nv_reg && !note_stall)
        begin
            nv_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    val_next   = freq_millihz;
                    stage_next = STAGE_OCT;
                    code_next  = '0;
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                code_next = code_reg + digit;
                if (stage_reg == STAGE_XFINE)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    val_next   = div_quot;
                    stage_next = stage_reg + 2'd1;
                    state_next = ST_SEARCH;
                end
            end
            ST_FINISH:
            begin
                if (!nv_reg || !note_stall)
                begin
                    nv_next    = 1'b1;
                    nc_next    = code_reg;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            nv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            nv_reg    <= nv_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        stage_reg <= stage_next;
        val_reg   <= val_next;
        code_reg  <= code_next;
        nc_reg    <= nc_next;
    end

    assign freq_stall = (state_reg != ST_IDLE);
    assign note_valid = nv_reg;
    assign note_code  = nc_reg;

    `ASSERT_NXT(a_accept_busy, clk, rst_n, accept, freq_stall)
    `ASSERT_IMP(a_done_in_div, clk, rst_n, div_done, state_reg == ST_DIV)
    `ASSERT_NXT(a_finish_loads, clk, rst_n, (state_reg == ST_FINISH) && !nv_reg,
                nv_reg && (state_reg == ST_IDLE))

endmodule
